// ----- rtl/core/bffa_pkg.sv -----
// Package for the bitmap first-fit allocator: status codes and field widths.
// No dependencies.
package bffa_pkg;
   localparam int unsigned SizeWidth   = 13;
   localparam int unsigned PageWidth   = 6;
   localparam int unsigned OffsetWidth = 12;
   localparam int unsigned HdrBytes    = 4;
   localparam int unsigned OffsetLimit = 4095;

   typedef enum logic [1:0] {
      STATUS_ALLOCATED = 2'd0,
      STATUS_NO_SPACE  = 2'd1,
      STATUS_FREED     = 2'd2,
      STATUS_BAD_ADDR  = 2'd3
   } status_type;
endpackage

// ----- rtl/core/bitmap_first_fit_allocator_unit.sv -----
// Top level of the bitmap first-fit allocator: sequencer, busy bitmap and size store.
// Depends on bffa_pkg.
//
// Usage: req_ beats carry one request each (tdata, lowest bit up: mode[0],
// request_size[13:1], release_page[19:14], release_offset[31:20]). rsp_ beats
// carry one result each (tdata: status[1:0], grant_page[7:2], grant_offset[19:8]).
// Requests are handled one at a time; req_tready is low while a request works.
// An allocation tests one bitmap bit at a time (one read port, registered data):
// each bit is read (ST_SRD), then tested (ST_STEST). A found run is then
// marked bit by bit (read, then write, per bit). A free reads the size entry,
// then clears each bit with a read, then a write. Each bit update is a
// read-modify-write of a word.
// After reset a clearing pass writes zero to every bitmap word and size entry;
// no request is taken meanwhile.
// The result waits in an output register while rsp_tready is low; the next
// request is taken once that beat has gone.
module bitmap_first_fit_allocator_unit #(
   parameter int unsigned PAGES       = 4,
   parameter int unsigned UNITS       = 3632,
   parameter int unsigned MAP_BYTES   = 484,
   parameter int unsigned MAX_REQUEST = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // mode, request_size, release_page, release_offset
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // status, grant_page, grant_offset
);
   import bffa_pkg::*;

   localparam int unsigned Words    = (UNITS + 31) / 32;
   localparam int unsigned MapDepth = PAGES * Words;
   localparam int unsigned SzDepth  = PAGES * UNITS;
   localparam int unsigned MapAw    = (MapDepth > 1) ? $clog2(MapDepth) : 1;
   localparam int unsigned SzAw     = (SzDepth > 1) ? $clog2(SzDepth) : 1;
   localparam int unsigned PgW      = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int unsigned PosW     = $clog2(UNITS + 1);
   localparam int unsigned ClrN     = (MapDepth > SzDepth) ? MapDepth : SzDepth;
   localparam int unsigned ClrW     = $clog2(ClrN + 1);

   typedef enum logic [10:0] {
      ST_CLEAR = 11'b00000000001,
      ST_IDLE  = 11'b00000000010,
      ST_SRD   = 11'b00000000100,
      ST_STEST = 11'b00000001000,
      ST_MRD   = 11'b00000010000,
      ST_MWR   = 11'b00000100000,
      ST_FRD   = 11'b00001000000,
      ST_FSZ   = 11'b00010000000,
      ST_CRD   = 11'b00100000000,
      ST_CWR   = 11'b01000000000,
      ST_OUT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [ClrW-1:0]        clr_ff, clr_in;
   logic [PgW-1:0]         page_ff, page_in;
   logic [PosW-1:0]        pos_ff, pos_in;     // bit under test / to update
   logic [PosW-1:0]        run_ff, run_in;     // free run length, then remaining
   logic [PosW-1:0]        start_ff, start_in;
   logic [SizeWidth-1:0]   size_ff, size_in;
   logic [13:0]            need_ff, need_in;
   logic                   mark_ff, mark_in;
   logic [1:0]             stat_ff, stat_in;
   logic [PageWidth-1:0]   gpage_ff, gpage_in;
   logic [OffsetWidth-1:0] goff_ff, goff_in;

   // bitmap memory: one registered read port, one write port
   logic [31:0] map_mem [MapDepth];
   logic [31:0] map_q;
   logic [MapAw-1:0] map_ra, map_wa;
   logic [31:0] map_wd;
   logic map_we;
   logic [SizeWidth-1:0] sz_mem [SzDepth];
   logic [SizeWidth-1:0] sz_q;
   logic [SzAw-1:0] sz_ra, sz_wa;
   logic [SizeWidth-1:0] sz_wd;
   logic sz_we;

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_wa] <= map_wd;
      map_q <= map_mem[map_ra];
      if (sz_we) sz_mem[sz_wa] <= sz_wd;
      sz_q <= sz_mem[sz_ra];
   end

   logic [MapAw-1:0] word_addr;
   logic [4:0]       bit_sel;
   logic             cur_bit;
   logic [13:0]      uoff;
   logic [SzAw-1:0]  sz_addr;
   logic             map_done, sz_done;

   assign word_addr = MapAw'(32'(page_ff) * Words + 32'(pos_ff >> 5));
   assign bit_sel   = pos_ff[4:0];
   assign cur_bit   = map_q[bit_sel];
   assign uoff      = 14'(MAP_BYTES + HdrBytes) + 14'(start_ff);
   assign sz_addr   = SzAw'(32'(page_ff) * UNITS + 32'(start_ff));
   assign map_done  = (32'(clr_ff) >= MapDepth);
   assign sz_done   = (32'(clr_ff) >= SzDepth);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {4'd0, goff_ff, gpage_ff, stat_ff};

   always_comb begin
      logic [SizeWidth-1:0] r_size;
      logic [PageWidth-1:0] r_page;
      logic [OffsetWidth-1:0] r_off;
      logic [13:0] r_need;
      logic [13:0] s_full;
      r_size = req_tdata[13:1];
      r_page = req_tdata[19:14];
      r_off  = req_tdata[31:20];
      r_need = 14'(r_size) + 14'(HdrBytes);
      s_full = 14'(r_off) - 14'(MAP_BYTES + HdrBytes);
      state_in = state_ff; clr_in = clr_ff; page_in = page_ff; pos_in = pos_ff;
      run_in = run_ff; start_in = start_ff; size_in = size_ff; need_in = need_ff;
      mark_in = mark_ff; stat_in = stat_ff; gpage_in = gpage_ff; goff_in = goff_ff;
      map_ra = word_addr; map_wa = word_addr; map_wd = map_q; map_we = 1'b0;
      sz_ra = sz_addr; sz_wa = sz_addr; sz_wd = '0; sz_we = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            map_wa = MapAw'(clr_ff); map_wd = '0; map_we = !map_done;
            sz_wa = SzAw'(clr_ff); sz_we = !sz_done;
            clr_in = clr_ff + 1'b1;
            if (map_done && sz_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               page_in = '0; pos_in = '0; run_in = '0;
               size_in = r_size; need_in = r_need;
               stat_in = STATUS_NO_SPACE; gpage_in = '0; goff_in = '0;
               if (!req_tdata[0]) begin
                  if (32'(r_size) > MAX_REQUEST || 32'(r_need) > UNITS)
                     state_in = ST_OUT;
                  else
                     state_in = ST_SRD;
               end else begin
                  page_in = PgW'(r_page);
                  start_in = PosW'(s_full);
                  if (32'(r_page) >= PAGES || 32'(r_off) < MAP_BYTES + HdrBytes ||
                      32'(s_full) + HdrBytes > UNITS) begin
                     stat_in = STATUS_BAD_ADDR; state_in = ST_OUT;
                  end else
                     state_in = ST_FRD;
               end
            end
         end
         ST_SRD: state_in = ST_STEST;
         ST_STEST: begin
            if (cur_bit) run_in = '0; else run_in = run_ff + 1'b1;
            if (!cur_bit && 14'(run_ff) + 14'd1 == need_ff) begin
               start_in = PosW'(14'(pos_ff) + 14'd1 - need_ff);
               state_in = ST_MRD;
               pos_in = PosW'(14'(pos_ff) + 14'd1 - need_ff);
               run_in = PosW'(need_ff);
               // offset overflow: skip whole page
               if (32'(MAP_BYTES + HdrBytes) + 32'(pos_ff) + 1 - 32'(need_ff) >
                   OffsetLimit) begin
                  pos_in = PosW'(UNITS - 1);
                  state_in = ST_STEST;
                  run_in = '0;
                  if (32'(page_ff) == PAGES - 1) state_in = ST_OUT;
                  else begin
                     page_in = page_ff + 1'b1; pos_in = '0; state_in = ST_SRD;
                  end
               end
            end else if (32'(pos_ff) == UNITS - 1) begin
               run_in = '0; pos_in = '0;
               if (32'(page_ff) == PAGES - 1) state_in = ST_OUT;
               else begin page_in = page_ff + 1'b1; state_in = ST_SRD; end
            end else begin
               pos_in = pos_ff + 1'b1; state_in = ST_SRD;
            end
            mark_in = 1'b1;
         end
         ST_MRD: state_in = ST_MWR;
         ST_MWR: begin
            map_wd = map_q; map_wd[bit_sel] = mark_ff; map_we = 1'b1;
            pos_in = pos_ff + 1'b1; run_in = run_ff - 1'b1;
            state_in = ST_MRD;
            if (run_ff == PosW'(1) || 32'(pos_ff) == UNITS - 1) begin
               state_in = ST_OUT;
               if (mark_ff) begin
                  sz_wd = size_ff; sz_we = 1'b1;
                  stat_in = STATUS_ALLOCATED;
                  gpage_in = PageWidth'(page_ff); goff_in = OffsetWidth'(uoff);
               end else
                  stat_in = STATUS_FREED;
            end
         end
         ST_FRD: state_in = ST_FSZ;
         ST_FSZ: begin
            sz_we = 1'b1; sz_wd = '0;
            run_in = PosW'(14'(sz_q) + 14'(HdrBytes) > 14'(UNITS) ?
                           14'(UNITS) : 14'(sz_q) + 14'(HdrBytes));
            pos_in = start_ff; mark_in = 1'b0; state_in = ST_MRD;
         end
         ST_CRD, ST_CWR: state_in = ST_IDLE;
         ST_OUT: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      page_ff <= page_in; pos_ff <= pos_in; run_ff <= run_in; start_ff <= start_in;
      size_ff <= size_in; need_ff <= need_in; mark_ff <= mark_in;
      stat_ff <= stat_in; gpage_ff <= gpage_in; goff_ff <= goff_in;
   end
endmodule

// ----- rtl/core/bffa_checker.sv -----
// Port-level checker for the bitmap first-fit allocator, bound to the top level.
// Depends on bffa_pkg.
module bffa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   import bffa_pkg::*;

   // never take a request while a result waits
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result pending");
   // a result beat that is not a grant carries zero page and offset
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != STATUS_ALLOCATED |-> rsp_tdata[19:2] == '0)
      else $error("non-grant carries address");
   // an accepted request is never answered in the next cycle's ready window
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready after accept");
   // a held result keeps its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
endmodule

bind bitmap_first_fit_allocator_unit bffa_checker u_bffa_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
